// ----- rtl/msseq_pkg.sv -----
// Shared constants, types and helper functions for the motion segment sequencer.
`default_nettype none
package msseq_pkg;

  localparam int SEG_SLOTS   = 16;
  localparam int PTR_W       = (SEG_SLOTS > 1) ? $clog2(SEG_SLOTS) : 1;

  localparam int REQ_W       = 3;
  localparam int WORD_W      = 32;
  localparam int DUR_W       = 34;
  localparam int MODE_W      = 2;
  localparam int QCNT_W      = 4;

  localparam int IN_TDATA_W  = 224;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_USED_W  = 138;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESUME = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ESTOP  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ESTOP = 2'd3;

  typedef struct packed {
    logic [DUR_W-1:0]  duration;
    logic [WORD_W-1:0] sid;
    logic [WORD_W-1:0] tx;
    logic [WORD_W-1:0] ty;
    logic [WORD_W-1:0] tz;
  } queue_entry_t;

  localparam int ENTRY_W = $bits(queue_entry_t);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SEG_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W:0] ring_count(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
    if (wp >= rp) begin
      return {1'b0, wp} - {1'b0, rp};
    end else begin
      return {1'b0, wp} + (PTR_W + 1)'(SEG_SLOTS) - {1'b0, rp};
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/msseq_queue_ram.sv -----
// Single write port, single registered read port memory for the segment queue.
`default_nettype none
module msseq_queue_ram #(
  parameter int DATA_W = 162,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/motion_segment_sequencer.sv -----
// Top level of the motion segment sequencer: command decode, run state and queue control.
//
// Requests arrive on the in_ channel: in_tuser carries the request type, in_tdata the
// segment fields used by a push. Every request produces exactly one result on the out_
// channel with the acceptance flag, run state, alarm, queue count, active segment status
// and the current axis positions.
// Segments wait in a ring queue held in a memory with a registered read port.
// Most requests complete at the accepting edge, where their result is registered.
// A tick that takes a segment from the queue also needs the queue memory read, so that
// request passes through the ST_POP state, and in_tready is low while it is there.
// The output register holds a result until it is taken; a new request is taken in the
// same cycle the pending result leaves, so a stalled receiver stalls the input side.
// Reset (rst_n low, synchronous) empties the queue, returns to idle, clears the alarm,
// the active segment and the positions. Queue entries are not cleared; no pass is run.
`default_nettype none
module motion_segment_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // seg_id, accel_len, cruise_len, decel_len, target_x, target_y, target_z
  input  wire logic [msseq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  wire logic [msseq_pkg::REQ_W-1:0]        in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // accepted, run_state, estop_alarm, queue_count, segment_active, segment_done,
  // active_id, pos_x, pos_y, pos_z, zero padding
  output logic      [msseq_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import msseq_pkg::*;

  localparam logic ST_IN  = 1'b0;
  localparam logic ST_POP = 1'b1;

  logic              state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              alarm_r, alarm_nxt;
  logic              busy_r, busy_nxt;
  logic [DUR_W-1:0]  elapsed_r, elapsed_nxt;
  logic [DUR_W-1:0]  cur_dur_r, cur_dur_nxt;
  logic [WORD_W-1:0] cur_tx_r, cur_tx_nxt;
  logic [WORD_W-1:0] cur_ty_r, cur_ty_nxt;
  logic [WORD_W-1:0] cur_tz_r, cur_tz_nxt;
  logic [WORD_W-1:0] cur_sid_r, cur_sid_nxt;
  logic [WORD_W-1:0] pos_x_r, pos_x_nxt;
  logic [WORD_W-1:0] pos_y_r, pos_y_nxt;
  logic [WORD_W-1:0] pos_z_r, pos_z_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic              in_fire;
  logic              out_load;
  logic              acc;
  logic              done;
  logic              wr_en;
  logic [DUR_W-1:0]  elapsed_inc;
  logic [PTR_W:0]    cnt_nxt;
  queue_entry_t      wr_entry;
  queue_entry_t      rd_entry;
  logic [ENTRY_W-1:0] rd_bits;

  assign in_tready = (state_r == ST_IN) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign wr_entry.duration = DUR_W'(in_tdata[63:32]) + DUR_W'(in_tdata[95:64])
                           + DUR_W'(in_tdata[127:96]);
  assign wr_entry.sid      = in_tdata[31:0];
  assign wr_entry.tx       = in_tdata[159:128];
  assign wr_entry.ty       = in_tdata[191:160];
  assign wr_entry.tz       = in_tdata[223:192];
  assign rd_entry          = queue_entry_t'(rd_bits);

  assign elapsed_inc = elapsed_r + 1'b1;

  msseq_queue_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (SEG_SLOTS),
    .ADDR_W (PTR_W)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (wr_entry),
    .rd_en   (in_fire),
    .rd_addr (rp_r),
    .rd_data (rd_bits)
  );

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    mode_nxt    = mode_r;
    alarm_nxt   = alarm_r;
    busy_nxt    = busy_r;
    elapsed_nxt = elapsed_r;
    cur_dur_nxt = cur_dur_r;
    cur_tx_nxt  = cur_tx_r;
    cur_ty_nxt  = cur_ty_r;
    cur_tz_nxt  = cur_tz_r;
    cur_sid_nxt = cur_sid_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    pos_z_nxt   = pos_z_r;
    acc         = 1'b0;
    done        = 1'b0;
    wr_en       = 1'b0;
    out_load    = 1'b0;

    if (state_r == ST_POP) begin
      cur_dur_nxt = rd_entry.duration;
      cur_tx_nxt  = rd_entry.tx;
      cur_ty_nxt  = rd_entry.ty;
      cur_tz_nxt  = rd_entry.tz;
      cur_sid_nxt = rd_entry.sid;
      rp_nxt      = ring_next(rp_r);
      busy_nxt    = 1'b1;
      elapsed_nxt = '0;
      acc         = 1'b1;
      out_load    = 1'b1;
      state_nxt   = ST_IN;
    end else if (in_fire) begin
      out_load = 1'b1;
      unique case (in_tuser)
        REQ_PUSH: begin
          if (ring_next(wp_r) != rp_r) begin
            wr_en  = 1'b1;
            wp_nxt = ring_next(wp_r);
            acc    = 1'b1;
          end
        end
        REQ_START: begin
          if (mode_r == MODE_IDLE || mode_r == MODE_PAUSE) begin
            mode_nxt = MODE_RUN;
            acc      = 1'b1;
          end
        end
        REQ_PAUSE: begin
          if (mode_r == MODE_RUN) begin
            mode_nxt = MODE_PAUSE;
            acc      = 1'b1;
          end
        end
        REQ_RESUME: begin
          if (mode_r == MODE_PAUSE) begin
            mode_nxt = MODE_RUN;
            acc      = 1'b1;
          end
        end
        REQ_STOP: begin
          mode_nxt = MODE_IDLE;
          wp_nxt   = '0;
          rp_nxt   = '0;
          busy_nxt = 1'b0;
          acc      = 1'b1;
        end
        REQ_ESTOP: begin
          mode_nxt  = MODE_ESTOP;
          alarm_nxt = 1'b1;
          wp_nxt    = '0;
          rp_nxt    = '0;
          busy_nxt  = 1'b0;
          acc       = 1'b1;
        end
        REQ_TICK: begin
          if (mode_r == MODE_RUN) begin
            acc = 1'b1;
            if (!busy_r) begin
              if (wp_r != rp_r) begin
                state_nxt = ST_POP;
                out_load  = 1'b0;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end else begin
              elapsed_nxt = elapsed_inc;
              if (elapsed_inc >= cur_dur_r) begin
                pos_x_nxt = cur_tx_r;
                pos_y_nxt = cur_ty_r;
                pos_z_nxt = cur_tz_r;
                busy_nxt  = 1'b0;
                done      = 1'b1;
              end
            end
          end
        end
        REQ_CLEAR: begin
          wp_nxt = '0;
          rp_nxt = '0;
          acc    = 1'b1;
        end
        default: begin
        end
      endcase
    end

    cnt_nxt = ring_count(wp_nxt, rp_nxt);

    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      wp_r        <= '0;
      rp_r        <= '0;
      mode_r      <= MODE_IDLE;
      alarm_r     <= 1'b0;
      busy_r      <= 1'b0;
      elapsed_r   <= '0;
      cur_dur_r   <= '0;
      cur_tx_r    <= '0;
      cur_ty_r    <= '0;
      cur_tz_r    <= '0;
      cur_sid_r   <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      mode_r      <= mode_nxt;
      alarm_r     <= alarm_nxt;
      busy_r      <= busy_nxt;
      elapsed_r   <= elapsed_nxt;
      cur_dur_r   <= cur_dur_nxt;
      cur_tx_r    <= cur_tx_nxt;
      cur_ty_r    <= cur_ty_nxt;
      cur_tz_r    <= cur_tz_nxt;
      cur_sid_r   <= cur_sid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(OUT_TDATA_W - OUT_USED_W)'(0),
                     pos_z_nxt, pos_y_nxt, pos_x_nxt, cur_sid_nxt,
                     done, busy_nxt, QCNT_W'(cnt_nxt),
                     alarm_nxt, mode_nxt, acc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- tb/tb_motion_segment_sequencer.sv -----
// Testbench for the motion segment sequencer with random requests and a local predictor.
`timescale 1ns / 1ps
module tb_motion_segment_sequencer;
  import msseq_pkg::*;

  localparam int TOTAL_REQUESTS   = 1300;
  localparam int FREE_PHASE_START = 1150;

  typedef struct packed {
    logic [REQ_W-1:0]         kind;
    logic [WORD_W-1:0]        seg_id;
    logic [WORD_W-1:0]        accel;
    logic [WORD_W-1:0]        cruise;
    logic [WORD_W-1:0]        decel;
    logic signed [WORD_W-1:0] tx;
    logic signed [WORD_W-1:0] ty;
    logic signed [WORD_W-1:0] tz;
  } request_t;

  typedef struct packed {
    logic                     accepted;
    logic [MODE_W-1:0]        run_state;
    logic                     alarm;
    logic [QCNT_W-1:0]        count;
    logic                     active;
    logic                     done;
    logic [WORD_W-1:0]        active_id;
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
  } status_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  status_t status_expected[$];
  int      errors        = 0;
  int      requests_sent = 0;
  int      stall_cycles  = 0;
  bit      src_idle_en   = 1'b1;
  bit      sink_idle_en  = 1'b1;

  logic [DUR_W-1:0]  seg_duration [SEG_SLOTS];
  logic [WORD_W-1:0] seg_ident    [SEG_SLOTS];
  logic [WORD_W-1:0] seg_goal     [SEG_SLOTS][3];
  logic [PTR_W-1:0]  wr_ptr     = '0;
  logic [PTR_W-1:0]  rd_ptr     = '0;
  logic [MODE_W-1:0] run_mode   = MODE_IDLE;
  logic              alarm_set  = 1'b0;
  logic              seg_busy   = 1'b0;
  logic [DUR_W-1:0]  tick_count = '0;
  logic [DUR_W-1:0]  seg_length = '0;
  logic [WORD_W-1:0] goal [3]   = '{default: '0};
  logic [WORD_W-1:0] cur_ident  = '0;
  logic [WORD_W-1:0] axis [3]   = '{default: '0};

  motion_segment_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic status_t predict_status(input request_t r);
    status_t          s;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_next;
    s = '0;
    wr_next = PTR_W'((int'(wr_ptr) + 1) % SEG_SLOTS);
    rd_next = PTR_W'((int'(rd_ptr) + 1) % SEG_SLOTS);
    case (r.kind)
      REQ_PUSH: begin
        if (wr_next != rd_ptr) begin
          seg_duration[wr_ptr] = DUR_W'(r.accel) + DUR_W'(r.cruise) + DUR_W'(r.decel);
          seg_ident[wr_ptr]    = r.seg_id;
          seg_goal[wr_ptr][0]  = r.tx;
          seg_goal[wr_ptr][1]  = r.ty;
          seg_goal[wr_ptr][2]  = r.tz;
          wr_ptr = wr_next;
          s.accepted = 1'b1;
        end
      end
      REQ_START: begin
        if (run_mode == MODE_IDLE || run_mode == MODE_PAUSE) begin
          run_mode = MODE_RUN;
          s.accepted = 1'b1;
        end
      end
      REQ_PAUSE: begin
        if (run_mode == MODE_RUN) begin
          run_mode = MODE_PAUSE;
          s.accepted = 1'b1;
        end
      end
      REQ_RESUME: begin
        if (run_mode == MODE_PAUSE) begin
          run_mode = MODE_RUN;
          s.accepted = 1'b1;
        end
      end
      REQ_STOP: begin
        run_mode = MODE_IDLE;
        wr_ptr = '0;
        rd_ptr = '0;
        seg_busy = 1'b0;
        s.accepted = 1'b1;
      end
      REQ_ESTOP: begin
        run_mode = MODE_ESTOP;
        alarm_set = 1'b1;
        wr_ptr = '0;
        rd_ptr = '0;
        seg_busy = 1'b0;
        s.accepted = 1'b1;
      end
      REQ_TICK: begin
        if (run_mode == MODE_RUN) begin
          s.accepted = 1'b1;
          if (!seg_busy) begin
            if (wr_ptr != rd_ptr) begin
              seg_length = seg_duration[rd_ptr];
              goal       = seg_goal[rd_ptr];
              cur_ident  = seg_ident[rd_ptr];
              rd_ptr     = rd_next;
              seg_busy   = 1'b1;
              tick_count = '0;
            end else begin
              run_mode = MODE_IDLE;
            end
          end else begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= seg_length) begin
              axis     = goal;
              seg_busy = 1'b0;
              s.done   = 1'b1;
            end
          end
        end
      end
      REQ_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        s.accepted = 1'b1;
      end
    endcase
    s.run_state = run_mode;
    s.alarm     = alarm_set;
    s.count     = QCNT_W'((int'(wr_ptr) + SEG_SLOTS - int'(rd_ptr)) % SEG_SLOTS);
    s.active    = seg_busy;
    s.active_id = cur_ident;
    s.pos_x     = axis[0];
    s.pos_y     = axis[1];
    s.pos_z     = axis[2];
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    status_t  seen;
    status_t  want;
    request_t req;
    if (rst_n && out_tvalid && out_tready) begin
      seen.accepted  = out_tdata[0];
      seen.run_state = out_tdata[2:1];
      seen.alarm     = out_tdata[3];
      seen.count     = out_tdata[7:4];
      seen.active    = out_tdata[8];
      seen.done      = out_tdata[9];
      seen.active_id = out_tdata[41:10];
      seen.pos_x     = out_tdata[73:42];
      seen.pos_y     = out_tdata[105:74];
      seen.pos_z     = out_tdata[137:106];
      if (status_expected.size() == 0) begin
        $error("Result arrived with no request outstanding");
        errors++;
      end else begin
        want = status_expected.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(seen.accepted));
        check_field("run_state", 64'(want.run_state), 64'(seen.run_state));
        check_field("estop_alarm", 64'(want.alarm), 64'(seen.alarm));
        check_field("queue_count", 64'(want.count), 64'(seen.count));
        check_field("segment_active", 64'(want.active), 64'(seen.active));
        check_field("segment_done", 64'(want.done), 64'(seen.done));
        check_field("active_id", 64'(want.active_id), 64'(seen.active_id));
        check_field("pos_x", 64'(want.pos_x), 64'(seen.pos_x));
        check_field("pos_y", 64'(want.pos_y), 64'(seen.pos_y));
        check_field("pos_z", 64'(want.pos_z), 64'(seen.pos_z));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      req.kind   = in_tuser;
      req.seg_id = in_tdata[31:0];
      req.accel  = in_tdata[63:32];
      req.cruise = in_tdata[95:64];
      req.decel  = in_tdata[127:96];
      req.tx     = in_tdata[159:128];
      req.ty     = in_tdata[191:160];
      req.tz     = in_tdata[223:192];
      status_expected.push_back(predict_status(req));
    end
  end

  initial begin : receiver
    int hold;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_cycles > 0) begin
        hold = stall_cycles;
        stall_cycles = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input request_t r);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {r.tz, r.ty, r.tx, r.decel, r.cruise, r.accel, r.seg_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  function automatic request_t random_request(input logic [REQ_W-1:0] kind);
    request_t r;
    r.kind   = kind;
    r.seg_id = $urandom;
    r.accel  = $urandom;
    r.cruise = $urandom;
    r.decel  = $urandom;
    r.tx     = $urandom;
    r.ty     = $urandom;
    r.tz     = $urandom;
    return r;
  endfunction

  // Mostly short segments so that they finish; now and then one that runs for ages.
  function automatic request_t random_segment();
    request_t r;
    r = random_request(REQ_PUSH);
    if ($urandom_range(0, 19) != 0) begin
      r.accel  = $urandom_range(0, 3);
      r.cruise = $urandom_range(0, 4);
      r.decel  = $urandom_range(0, 3);
    end
    return r;
  endfunction

  function automatic request_t make_segment(input logic [WORD_W-1:0] id,
                                            input logic [WORD_W-1:0] a, c, d,
                                            input logic [WORD_W-1:0] x, y, z);
    request_t r;
    r.kind   = REQ_PUSH;
    r.seg_id = id;
    r.accel  = a;
    r.cruise = c;
    r.decel  = d;
    r.tx     = x;
    r.ty     = y;
    r.tz     = z;
    return r;
  endfunction

  task automatic issue(input logic [REQ_W-1:0] kind);
    send_request(random_request(kind));
  endtask

  // Fills the queue past its capacity; the last push must be refused.
  task automatic test_queue_full();
    send_request(make_segment('0, '0, '0, '0, '0, '0, '0));
    send_request(make_segment('1, '1, '1, '1, '1, '1, '1));
    send_request(make_segment(32'h1234_5678, 32'd1, 32'd0, 32'd0,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_request(make_segment(32'h8765_4321, 32'd0, 32'd2, 32'd1,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    repeat (SEG_SLOTS - 4) send_request(random_segment());
  endtask

  // Walks the run states, including commands that must be ignored.
  task automatic test_run_control();
    issue(REQ_START);
    issue(REQ_START);
    issue(REQ_TICK);
    issue(REQ_TICK);
    issue(REQ_TICK);
    issue(REQ_TICK);
    issue(REQ_PAUSE);
    issue(REQ_PAUSE);
    issue(REQ_RESUME);
    issue(REQ_RESUME);
    issue(REQ_CLEAR);
    issue(REQ_TICK);
    issue(REQ_STOP);
    issue(REQ_TICK);
    issue(REQ_RESUME);
  endtask

  task automatic test_estop();
    issue(REQ_ESTOP);
    issue(REQ_START);
    issue(REQ_PAUSE);
    issue(REQ_RESUME);
    issue(REQ_TICK);
    issue(REQ_STOP);
    issue(REQ_START);
    issue(REQ_TICK);
  endtask

  // Push a few segments, start, and tick long enough to drain them unless one runs long.
  task automatic run_program();
    request_t seg;
    longint   dur;
    int       n_segs;
    int       tick_budget;
    bit       has_long;
    n_segs = $urandom_range(1, 6);
    tick_budget = 1;
    has_long = 1'b0;
    for (int i = 0; i < n_segs; i++) begin
      seg = random_segment();
      dur = longint'(seg.accel) + longint'(seg.cruise) + longint'(seg.decel);
      if (dur > 40) has_long = 1'b1;
      else tick_budget += 2 + int'(dur);
      send_request(seg);
    end
    if (run_mode == MODE_ESTOP || $urandom_range(0, 5) == 0) issue(REQ_STOP);
    issue(REQ_START);
    tick_budget += $urandom_range(0, 3);
    for (int t = 0; t < tick_budget; t++) begin
      if ($urandom_range(0, 15) == 0) begin
        issue(REQ_PAUSE);
        if ($urandom_range(0, 1) == 1) issue(REQ_TICK);
        issue(REQ_RESUME);
      end
      issue(REQ_TICK);
    end
    case ($urandom_range(0, 7))
      0: issue(REQ_STOP);
      1: issue(REQ_ESTOP);
      2: issue(REQ_CLEAR);
      default: ;
    endcase
    if (has_long) issue(REQ_STOP);
  endtask

  task automatic send_noise();
    request_t r;
    repeat ($urandom_range(1, 8)) begin
      r = random_request(REQ_W'($urandom_range(0, 7)));
      if (r.kind == REQ_PUSH) r = random_segment();
      send_request(r);
    end
  endtask

  task automatic test_random_programs();
    while (requests_sent < FREE_PHASE_START) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) run_program();
      else send_noise();
    end
  endtask

  // The receiver holds off while requests keep coming, so the input side backs up.
  task automatic test_output_stall();
    stall_cycles = 300;
    repeat (24) send_request(random_request(REQ_W'($urandom_range(0, 7))));
    issue(REQ_STOP);
  endtask

  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    while (requests_sent < TOTAL_REQUESTS) run_program();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_PUSH;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_queue_full();
    test_run_control();
    test_estop();
    test_random_programs();
    test_output_stall();
    test_back_to_back();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
